// ===== rtl/core/hts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

    localparam int NUM_LENGTHS     = 16;
    localparam int MAX_CODE_LENGTH = 16;
    localparam int CODE_W          = 17;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_CLASS = 3'd1;
    localparam logic [2:0] STATUS_BAD_ID    = 3'd2;
    localparam logic [2:0] STATUS_EARLY_END = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW  = 3'd4;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COUNTS,
        PH_SYMBOLS,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic process;
        logic advance;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_advance;
        logic advance_done;
        logic pend_emit;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/huffman_table_segment_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Parses the payload of a JPEG huffman-table segment, one byte per request, and
// returns one result per symbol with its canonical codeword, one per error and
// one for the last byte of the segment. Each byte is first taken in, and its
// result is then posted. After the sixteenth count of a table, and after the
// last symbol of a length, the datapath steps through the code lengths at one
// length per cycle until it finds one with symbols left or passes the last
// length, ahead of that byte's result. The next byte is taken while a result
// still waits in the output register; a second result waits for it to drain.

module huffman_table_segment_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             has_codeword,
    output logic             table_class,
    output logic [1:0]       table_id,
    output logic [15:0]      code_bits,
    output logic [4:0]       code_length,
    output logic [7:0]       symbol_value,
    output logic             segment_end,
    output logic [2:0]       status
);
    import hts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    hts_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    hts_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .has_codeword (has_codeword),
        .table_class  (table_class),
        .table_id     (table_id),
        .code_bits    (code_bits),
        .code_length  (code_length),
        .symbol_value (symbol_value),
        .segment_end  (segment_end),
        .status       (status)
    );

    // one byte in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while previous byte still in work");

    a_codeword_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_codeword) |->
            (status == STATUS_OK && code_length != 5'd0
             && code_length <= 5'(MAX_CODE_LENGTH)))
        else $error("codeword result with bad length or status");

    a_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_codeword) |-> ((code_bits >> code_length) == 16'd0))
        else $error("codeword wider than its length");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_codeword) |->
            (code_bits == 16'd0 && code_length == 5'd0 && symbol_value == 8'd0
             && table_class == 1'b0 && table_id == 2'd0))
        else $error("non-codeword result carries codeword fields");

endmodule

`default_nettype wire

// ===== rtl/core/hts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hts_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hts_pkg::dp_cmd_t   cmd,
    output hts_pkg::dp_status_t     stat,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output logic                    has_codeword,
    output logic                    table_class,
    output logic [1:0]              table_id,
    output logic [15:0]             code_bits,
    output logic [4:0]              code_length,
    output logic [7:0]              symbol_value,
    output logic                    segment_end,
    output logic [2:0]              status
);
    import hts_pkg::*;

    // table walk state
    phase_t              phase_reg, phase_next;
    logic                class_reg, class_next;
    logic [1:0]          id_reg, id_next;
    logic [3:0]          count_index_reg, count_index_next;
    logic [4:0]          length_index_reg, length_index_next;
    logic [7:0]          symbols_left_reg, symbols_left_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [7:0]          counts_reg [NUM_LENGTHS];

    // result of the byte in flight
    logic                p_hc_reg, p_hc_next;
    logic [15:0]         p_code_reg, p_code_next;
    logic [4:0]          p_len_reg, p_len_next;
    logic [7:0]          p_sym_reg, p_sym_next;
    logic [2:0]          p_st_reg, p_st_next;
    logic                p_err_reg, p_err_next;
    logic                p_last_reg, p_last_next;
    logic                p_emit_reg, p_emit_next;

    // output register
    logic                o_hc_reg, o_hc_next;
    logic                o_class_reg, o_class_next;
    logic [1:0]          o_id_reg, o_id_next;
    logic [15:0]         o_code_reg, o_code_next;
    logic [4:0]          o_len_reg, o_len_next;
    logic [7:0]          o_sym_reg, o_sym_next;
    logic                o_end_reg, o_end_next;
    logic [2:0]          o_st_reg, o_st_next;

    logic [3:0]          hdr_class;
    logic [3:0]          hdr_id;
    logic [4:0]          idx_inc;
    logic [7:0]          sl_dec;
    logic                overflow;
    logic                counts_we;
    logic                need_adv;
    logic                err;
    logic                early_end;
    logic                fin_hc;

    assign hdr_class = data_byte[7:4];
    assign hdr_id    = data_byte[3:0];
    assign idx_inc   = length_index_reg + 5'd1;
    assign sl_dec    = symbols_left_reg - 8'd1;
    // code must fit in idx_inc bits, and the length must not exceed the limit
    assign overflow  = (idx_inc > 5'(MAX_CODE_LENGTH)) || ((code_reg >> idx_inc) != '0);

    assign early_end = !p_err_reg && p_last_reg
                       && (phase_reg == PH_COUNTS || phase_reg == PH_SYMBOLS);
    assign fin_hc    = p_hc_reg && !early_end;

    always_comb
    begin
        phase_next        = phase_reg;
        class_next        = class_reg;
        id_next           = id_reg;
        count_index_next  = count_index_reg;
        length_index_next = length_index_reg;
        symbols_left_next = symbols_left_reg;
        code_next         = code_reg;

        p_hc_next   = p_hc_reg;
        p_code_next = p_code_reg;
        p_len_next  = p_len_reg;
        p_sym_next  = p_sym_reg;
        p_st_next   = p_st_reg;
        p_err_next  = p_err_reg;
        p_last_next = p_last_reg;
        p_emit_next = p_emit_reg;

        o_hc_next    = o_hc_reg;
        o_class_next = o_class_reg;
        o_id_next    = o_id_reg;
        o_code_next  = o_code_reg;
        o_len_next   = o_len_reg;
        o_sym_next   = o_sym_reg;
        o_end_next   = o_end_reg;
        o_st_next    = o_st_reg;

        counts_we = 1'b0;
        need_adv  = 1'b0;
        err       = 1'b0;

        if (cmd.process)
        begin
            p_hc_next   = 1'b0;
            p_code_next = '0;
            p_len_next  = '0;
            p_sym_next  = '0;
            p_st_next   = STATUS_OK;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_class > 4'd1)
                    begin
                        err       = 1'b1;
                        p_st_next = STATUS_BAD_CLASS;
                    end
                    else if (hdr_id > 4'd3)
                    begin
                        err       = 1'b1;
                        p_st_next = STATUS_BAD_ID;
                    end
                    else
                    begin
                        class_next       = hdr_class[0];
                        id_next          = hdr_id[1:0];
                        count_index_next = '0;
                        phase_next       = PH_COUNTS;
                    end
                end
                PH_COUNTS:
                begin
                    counts_we = 1'b1;
                    if (count_index_reg == 4'(NUM_LENGTHS - 1))
                    begin
                        // index one below length 1, so the first advance step loads count 0
                        length_index_next = '1;
                        code_next         = '0;
                        symbols_left_next = '0;
                        need_adv          = 1'b1;
                    end
                    else
                    begin
                        count_index_next = count_index_reg + 4'd1;
                    end
                end
                PH_SYMBOLS:
                begin
                    if (overflow)
                    begin
                        err       = 1'b1;
                        p_st_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        p_hc_next         = 1'b1;
                        p_code_next       = code_reg[15:0];
                        p_len_next        = idx_inc;
                        p_sym_next        = data_byte;
                        code_next         = code_reg + CODE_W'(1);
                        symbols_left_next = sl_dec;
                        need_adv          = (sl_dec == 8'd0);
                    end
                end
                PH_DROP:
                begin
                end
            endcase
            if (err)
                phase_next = PH_DROP;
            p_err_next  = err;
            p_last_next = last_byte;
            p_emit_next = p_hc_next || err || last_byte;
        end

        // one skipped length per cycle
        if (cmd.advance)
        begin
            if (symbols_left_reg == 8'd0)
            begin
                code_next         = code_reg << 1;
                length_index_next = idx_inc;
                if (idx_inc[4])
                    phase_next = PH_HEADER;
                else
                    symbols_left_next = counts_reg[idx_inc[3:0]];
            end
            else
            begin
                phase_next = PH_SYMBOLS;
            end
        end

        if (cmd.finish)
        begin
            if (p_emit_reg)
            begin
                o_hc_next    = fin_hc;
                o_class_next = fin_hc ? class_reg : 1'b0;
                o_id_next    = fin_hc ? id_reg : 2'd0;
                o_code_next  = fin_hc ? p_code_reg : 16'd0;
                o_len_next   = fin_hc ? p_len_reg : 5'd0;
                o_sym_next   = fin_hc ? p_sym_reg : 8'd0;
                o_end_next   = p_last_reg;
                o_st_next    = early_end ? STATUS_EARLY_END : p_st_reg;
            end
            if (p_last_reg)
            begin
                phase_next        = PH_HEADER;
                count_index_next  = '0;
                length_index_next = '0;
                symbols_left_next = '0;
                code_next         = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            class_reg        <= 1'b0;
            id_reg           <= '0;
            count_index_reg  <= '0;
            length_index_reg <= '0;
            symbols_left_reg <= '0;
            code_reg         <= '0;
            p_err_reg        <= 1'b0;
            p_last_reg       <= 1'b0;
            p_emit_reg       <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            class_reg        <= class_next;
            id_reg           <= id_next;
            count_index_reg  <= count_index_next;
            length_index_reg <= length_index_next;
            symbols_left_reg <= symbols_left_next;
            code_reg         <= code_next;
            p_err_reg        <= p_err_next;
            p_last_reg       <= p_last_next;
            p_emit_reg       <= p_emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (counts_we)
            counts_reg[count_index_reg] <= data_byte;
        p_hc_reg    <= p_hc_next;
        p_code_reg  <= p_code_next;
        p_len_reg   <= p_len_next;
        p_sym_reg   <= p_sym_next;
        p_st_reg    <= p_st_next;
        o_hc_reg    <= o_hc_next;
        o_class_reg <= o_class_next;
        o_id_reg    <= o_id_next;
        o_code_reg  <= o_code_next;
        o_len_reg   <= o_len_next;
        o_sym_reg   <= o_sym_next;
        o_end_reg   <= o_end_next;
        o_st_reg    <= o_st_next;
    end

    assign stat.need_advance = need_adv;
    assign stat.advance_done = (symbols_left_reg != 8'd0) || idx_inc[4];
    assign stat.pend_emit    = p_emit_reg;

    assign has_codeword = o_hc_reg;
    assign table_class  = o_class_reg;
    assign table_id     = o_id_reg;
    assign code_bits    = o_code_reg;
    assign code_length  = o_len_reg;
    assign symbol_value = o_sym_reg;
    assign segment_end  = o_end_reg;
    assign status       = o_st_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hts_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hts_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hts_pkg::dp_cmd_t          cmd,
    input  wire hts_pkg::dp_status_t  stat
);
    import hts_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.process = 1'b1;
                    state_next  = stat.need_advance ? ST_ADVANCE : ST_FINISH;
                end
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                if (stat.advance_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the result until the output register can take it
                if (!stat.pend_emit || slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    if (stat.pend_emit)
                        out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
